[sv/dott_pkg.sv]
`timescale 1ns / 1ps
package dott_pkg;

	localparam logic [2:0] MODE_ADD     = 3'd0;
	localparam logic [2:0] MODE_CANCEL  = 3'd1;
	localparam logic [2:0] MODE_REFRESH = 3'd2;
	localparam logic [2:0] MODE_RESET   = 3'd3;
	localparam logic [2:0] MODE_EXPIRE  = 3'd4;
	localparam logic [2:0] MODE_QUERY   = 3'd5;

	localparam logic [31:0] DEFAULT_WINDOW_MS = 32'd3600000;
	localparam logic [63:0] NO_DEADLINE       = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        rec;
		logic [31:0] per;
		logic [63:0] dl;
	} slot_word_t;

	localparam int WORD_W = $bits(slot_word_t);

endpackage

[sv/deadline_ordered_timer_table_unit.sv]
`timescale 1ns / 1ps
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | mode timer_id interval_ms recurring restart_now now_ms
// out     | output    | out_valid/out_stall | ok slot fired front_changed next_delay_ms
//         |           |                   | any_active last
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (rollover_window_ms)
//
// One item at a time; in_stall is high from transfer until its last result is loaded.
// Cancel, undefined modes, bad ids, full add, empty-table expire: no scan, straight to S_EMIT.
// Add, query: one slot table scan through the RAM read port;
// refresh and reset read the slot first (reset skips the scan when it leaves the slot as is).
// Expire: one scan for the due set, then one selection scan per fired slot;
// output stalls hold the sequencer at each result.
// Reset clears all valid bits at once; slot RAM needs no clearing pass.
module deadline_ordered_timer_table_unit
	import dott_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [3:0]  timer_id,
	input  logic [31:0] interval_ms,
	input  logic        recurring,
	input  logic        restart_now,
	input  logic [63:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [3:0]  slot,
	output logic        fired,
	output logic        front_changed,
	output logic [63:0] next_delay_ms,
	output logic        any_active,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_PREP  = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_PLACE = 4'd4;
	localparam logic [3:0] S_XSEL  = 4'd5;
	localparam logic [3:0] S_QRES  = 4'd6;
	localparam logic [3:0] S_EMIT  = 4'd7;
	localparam logic [3:0] S_DUE   = 4'd8;

	logic [3:0]           state_q, nxt_q;
	logic [NUM_SLOTS-1:0] valid_q, mask_q, due_q;
	logic [63:0]          prev_q, now_q, d_q, best_d_q;
	logic [31:0]          window_q, ms_q, add_q, wr_per_q, best_per_q;
	logic [2:0]           mode_q;
	logic                 fnow_q, wr_rec_q, best_rec_q, best_v_q, notify_q;
	logic                 roll_q, act_q, due_scan_q, act_sel_q;
	logic [IW-1:0]        slot_q, best_i_q, rd_idx_s1;
	logic [CW-1:0]        scan_cnt_q;
	logic                 rd_v_s1;
	logic                 r_ok_q, r_fired_q, r_front_q, r_last_q;
	logic [3:0]           r_slot_q;
	logic [63:0]          r_delay_q;
	logic                 out_v_q, ok_q, fired_q, front_q, act_out_q, last_q;
	logic [3:0]           slot_out_q;
	logic [63:0]          delay_q;

	logic [IW-1:0]        id_ix, free_ix, ram_raddr, ram_waddr;
	logic                 id_ok, full, ram_we, in_xfer, front;
	logic [WORD_W-1:0]    ram_rdata_raw;
	slot_word_t           rw, ram_wdata;
	logic [NUM_SLOTS-1:0] free_bit, slot_bit, best_bit;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign id_ix     = IW'(timer_id);
	assign id_ok     = (32'(timer_id) < NUM_SLOTS) && valid_q[id_ix];
	assign full      = &valid_q;
	assign free_bit  = NUM_SLOTS'(1) << free_ix;
	assign slot_bit  = NUM_SLOTS'(1) << slot_q;
	assign best_bit  = NUM_SLOTS'(1) << best_i_q;
	assign rw        = slot_word_t'(ram_rdata_raw);
	assign front     = !best_v_q || !((best_d_q < d_q) ||
		((best_d_q == d_q) && (best_i_q < slot_q)));

	always_comb begin
		free_ix = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--)
			if (!valid_q[i])
				free_ix = IW'(i);
	end

	assign ram_raddr = (state_q == S_IDLE) ? id_ix : scan_cnt_q[IW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = '{rec: wr_rec_q, per: wr_per_q, dl: d_q};
		if (state_q == S_PLACE) begin
			ram_we = 1'b1;
		end else if (state_q == S_XSEL && best_rec_q) begin
			ram_we    = 1'b1;
			ram_waddr = best_i_q;
			ram_wdata = '{rec: 1'b1, per: best_per_q, dl: now_q + 64'(best_per_q)};
		end
	end

	dott_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SLOTS), .AW(IW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			prev_q     <= '0;
			notify_q   <= 1'b0;
			window_q   <= DEFAULT_WINDOW_MS;
			out_v_q    <= 1'b0;
			rd_v_s1    <= 1'b0;
			scan_cnt_q <= '0;
		end else begin
			rd_v_s1 <= (state_q == S_SCAN) && (32'(scan_cnt_q) < NUM_SLOTS);
			if (cfg_valid && cfg_ready)
				window_q <= cfg_data;
			if (state_q == S_EMIT && (!out_v_q || !out_stall))
				out_v_q <= 1'b1;
			else if (out_v_q && !out_stall)
				out_v_q <= 1'b0;

			case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					mode_q    <= mode;
					ms_q      <= interval_ms;
					fnow_q    <= restart_now;
					now_q     <= now_ms;
					slot_q    <= (mode == MODE_ADD) ? free_ix : id_ix;
					r_slot_q  <= (mode == MODE_CANCEL || mode == MODE_REFRESH ||
						mode == MODE_RESET) ? timer_id : 4'd0;
					r_fired_q <= 1'b0;
					r_front_q <= 1'b0;
					r_last_q  <= 1'b1;
					r_delay_q <= '0;
					act_sel_q <= 1'b0;
					case (mode)
					MODE_ADD: begin
						r_ok_q <= 1'b0;
						if (full) begin
							state_q <= S_EMIT;
						end else begin
							d_q        <= now_ms + 64'(interval_ms);
							wr_rec_q   <= recurring;
							wr_per_q   <= interval_ms;
							mask_q     <= valid_q & ~free_bit;
							due_scan_q <= 1'b0;
							best_v_q   <= 1'b0;
							scan_cnt_q <= '0;
							nxt_q      <= S_PLACE;
							state_q    <= S_SCAN;
						end
					end
					MODE_CANCEL: begin
						r_ok_q <= id_ok;
						if (id_ok)
							valid_q[id_ix] <= 1'b0;
						state_q <= S_EMIT;
					end
					MODE_REFRESH, MODE_RESET: begin
						r_ok_q  <= id_ok;
						state_q <= id_ok ? S_RD : S_EMIT;
					end
					MODE_EXPIRE: begin
						r_ok_q <= 1'b1;
						if (valid_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							roll_q     <= (now_ms < prev_q) &&
								((prev_q - now_ms) > 64'(window_q));
							prev_q     <= now_ms;
							due_q      <= '0;
							act_q      <= 1'b0;
							due_scan_q <= 1'b1;
							scan_cnt_q <= '0;
							nxt_q      <= S_DUE;
							state_q    <= S_SCAN;
						end
					end
					MODE_QUERY: begin
						r_ok_q     <= 1'b1;
						notify_q   <= 1'b0;
						mask_q     <= valid_q;
						due_scan_q <= 1'b0;
						best_v_q   <= 1'b0;
						scan_cnt_q <= '0;
						nxt_q      <= S_QRES;
						state_q    <= S_SCAN;
					end
					default: begin
						r_ok_q  <= 1'b0;
						state_q <= S_EMIT;
					end
					endcase
				end
			end
			S_RD: begin
				wr_rec_q <= rw.rec;
				if (mode_q == MODE_REFRESH) begin
					d_q      <= now_q;
					add_q    <= rw.per;
					wr_per_q <= rw.per;
					state_q  <= S_PREP;
				end else if (ms_q == rw.per && !fnow_q) begin
					state_q <= S_EMIT;
				end else begin
					d_q      <= fnow_q ? now_q : rw.dl - 64'(rw.per);
					add_q    <= ms_q;
					wr_per_q <= ms_q;
					state_q  <= S_PREP;
				end
			end
			S_PREP: begin
				d_q        <= d_q + 64'(add_q);
				mask_q     <= valid_q & ~slot_bit;
				due_scan_q <= 1'b0;
				best_v_q   <= 1'b0;
				scan_cnt_q <= '0;
				nxt_q      <= S_PLACE;
				state_q    <= S_SCAN;
			end
			S_SCAN: begin
				if (32'(scan_cnt_q) < NUM_SLOTS) begin
					rd_idx_s1  <= scan_cnt_q[IW-1:0];
					scan_cnt_q <= scan_cnt_q + CW'(1);
				end else if (!rd_v_s1) begin
					state_q <= nxt_q;
				end
				if (rd_v_s1) begin
					if (due_scan_q) begin
						if (valid_q[rd_idx_s1]) begin
							due_q[rd_idx_s1] <= roll_q || (rw.dl <= now_q);
							if (!(roll_q || (rw.dl <= now_q)) || rw.rec)
								act_q <= 1'b1;
						end
					end else if (mask_q[rd_idx_s1] && (!best_v_q || rw.dl < best_d_q)) begin
						best_v_q   <= 1'b1;
						best_d_q   <= rw.dl;
						best_i_q   <= rd_idx_s1;
						best_rec_q <= rw.rec;
						best_per_q <= rw.per;
					end
				end
			end
			S_PLACE: begin
				valid_q[slot_q] <= 1'b1;
				r_ok_q          <= 1'b1;
				if (mode_q == MODE_ADD)
					r_slot_q <= 4'(slot_q);
				if (front && !notify_q) begin
					notify_q  <= 1'b1;
					r_front_q <= 1'b1;
				end
				state_q <= S_EMIT;
			end
			S_DUE: begin
				if (due_q == '0) begin
					state_q <= S_EMIT;
				end else begin
					mask_q     <= due_q;
					due_scan_q <= 1'b0;
					best_v_q   <= 1'b0;
					scan_cnt_q <= '0;
					nxt_q      <= S_XSEL;
					state_q    <= S_SCAN;
				end
			end
			S_XSEL: begin
				if (!best_rec_q)
					valid_q[best_i_q] <= 1'b0;
				due_q     <= due_q & ~best_bit;
				r_slot_q  <= 4'(best_i_q);
				r_fired_q <= 1'b1;
				r_last_q  <= ((due_q & ~best_bit) == '0);
				act_sel_q <= 1'b1;
				state_q   <= S_EMIT;
			end
			S_QRES: begin
				if (!best_v_q)
					r_delay_q <= NO_DEADLINE;
				else
					r_delay_q <= (now_q >= best_d_q) ? 64'd0 : best_d_q - now_q;
				state_q <= S_EMIT;
			end
			S_EMIT: begin
				if (!out_v_q || !out_stall) begin
					ok_q       <= r_ok_q;
					slot_out_q <= r_slot_q;
					fired_q    <= r_fired_q;
					front_q    <= r_front_q;
					delay_q    <= r_delay_q;
					act_out_q  <= act_sel_q ? act_q : |valid_q;
					last_q     <= r_last_q;
					if (r_last_q) begin
						state_q <= S_IDLE;
					end else begin
						mask_q     <= due_q;
						due_scan_q <= 1'b0;
						best_v_q   <= 1'b0;
						scan_cnt_q <= '0;
						nxt_q      <= S_XSEL;
						state_q    <= S_SCAN;
					end
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_v_q;
	assign ok            = ok_q;
	assign slot          = slot_out_q;
	assign fired         = fired_q;
	assign front_changed = front_q;
	assign next_delay_ms = delay_q;
	assign any_active    = act_out_q;
	assign last          = last_q;

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (32'(scan_cnt_q) <= NUM_SLOTS))
		else $error("scan counter overran slot table");

	a_xsel_due: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_XSEL) |-> (best_v_q && due_q[best_i_q]))
		else $error("expire selected a slot outside the due set");

	a_add_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE && mode_q == MODE_ADD) |-> !valid_q[slot_q])
		else $error("add placed a timer in an occupied slot");

endmodule

[sv/dott_ram.sv]
`timescale 1ns / 1ps
module dott_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
